// ===== hdl/aata_pkg.sv =====
package aata_pkg;

    // Angle constants in Q2.30, wide enough for the reduction datapath.
    localparam int ANG_W = 48;
    localparam logic signed [ANG_W-1:0] Q30_PI      = 48'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 48'sd6746518852;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 48'sd1686629713;

    // CORDIC datapath in Q2.30.
    localparam int CORD_W = 34;
    localparam logic signed [CORD_W-1:0] Q30_CORDIC_GAIN = 34'sd652032874;
    localparam int ATAN_ENTRIES = 24;

    // The angle magnitude stays below Q30_TWO_PI shifted by this many bits.
    localparam int MOD_STEPS = 10;

    // Width of the shared multiplier operands.
    localparam int MUL_W = 33;

    function automatic logic signed [CORD_W-1:0] atan_q30(input logic [4:0] n);
        logic signed [CORD_W-1:0] r;
        unique case (n)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            5'd11:   r = 34'sd524288;
            5'd12:   r = 34'sd262144;
            5'd13:   r = 34'sd131072;
            5'd14:   r = 34'sd65536;
            5'd15:   r = 34'sd32768;
            5'd16:   r = 34'sd16384;
            5'd17:   r = 34'sd8192;
            5'd18:   r = 34'sd4096;
            5'd19:   r = 34'sd2048;
            5'd20:   r = 34'sd1024;
            5'd21:   r = 34'sd512;
            5'd22:   r = 34'sd256;
            5'd23:   r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/aata_req_if.sv =====
interface aata_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [19:0] angle;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;

    modport source (output valid, req_type, angle, value_x, value_y, value_z,
                    input ready);
    modport sink (input valid, req_type, angle, value_x, value_y, value_z,
                  output ready);
endinterface

// ===== hdl/aata_rsp_if.sv =====
interface aata_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  pos_x, pos_y, pos_z, output ready);
endinterface

// ===== hdl/axis_angle_transform_accumulator.sv =====
// Keeps a 3x3 rotation and a translation in signed fixed point with FRAC_BITS fractional
// bits. A set-position item overwrites the translation and its result follows in the next
// cycle. A rotate item normalizes the axis, takes sine and cosine of the angle by CORDIC,
// builds the Rodrigues matrix and right-multiplies the rotation by it; a zero axis leaves
// the state as it is and is answered right after the sum of squares. Everything runs on
// one 33x33 multiplier, one bit-serial square root, one restoring divider and one CORDIC
// stage under a sequencer, and no new item is taken until the result has been taken. A
// rotate item passes through the sum of squares, the square root, the divider for each
// axis, the angle reduction, the CORDIC iterations, the building of the matrix entry by
// entry and the matrix product, one multiply at a time. Every item returns all nine
// entries and the position.
module axis_angle_transform_accumulator #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    aata_req_if.sink    req,
    aata_rsp_if.source  rsp
);
    import aata_pkg::*;

    localparam int SH      = 30 - FRAC_BITS;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int DC_W    = $clog2(FRAC_BITS + 1);
    localparam int STEPS   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [MUL_W-1:0] ONE33 = 33'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SUMSQ, ST_SUMACC, ST_SQRT, ST_DIVI, ST_DIV, ST_MODI, ST_MOD,
        ST_FOLD, ST_CORDIC, ST_CSFIN, ST_UUTA, ST_UUT, ST_UUTACC, ST_COSM,
        ST_COSACC, ST_SINM, ST_SINACC, ST_RMUL, ST_RACC, ST_COMMIT, ST_OUT
    } state_t;

    state_t                    state_reg;
    logic [8:0][31:0]          rot_reg;
    logic [2:0][31:0]          tr_reg;
    logic [31:0]               mag_reg [3];
    logic [2:0]                sign_reg;
    logic signed [19:0]        angle_reg;
    logic [1:0]                idx_reg;
    logic [63:0]               sum_reg;
    logic [63:0]               sq_op_reg;
    logic [63:0]               sq_res_reg;
    logic [63:0]               sq_bit_reg;
    logic [31:0]               norm_reg;
    logic [33:0]               div_p_reg;
    logic [Q_W-1:0]            div_q_reg;
    logic [DC_W-1:0]           div_cnt_reg;
    logic signed [31:0]        u_reg [3];
    logic [ANG_W-1:0]          amag_reg;
    logic [3:0]                mod_cnt_reg;
    logic signed [CORD_W-1:0]  x_reg;
    logic signed [CORD_W-1:0]  y_reg;
    logic signed [CORD_W-1:0]  z_reg;
    logic                      negcos_reg;
    logic [4:0]                cord_cnt_reg;
    logic signed [MUL_W-1:0]   c_reg;
    logic signed [MUL_W-1:0]   s_reg;
    logic [1:0]                i_reg;
    logic [1:0]                j_reg;
    logic [1:0]                k_reg;
    logic signed [31:0]        ua_reg;
    logic signed [MUL_W-1:0]   uut_reg;
    logic signed [33:0]        mterm_reg;
    logic signed [31:0]        mb_reg [9];
    logic signed [63:0]        acc_reg;
    logic signed [31:0]        nxt_reg [9];
    logic signed [2*MUL_W-1:0] prod_reg;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [1:0]                u_rd_idx;
    logic signed [31:0]        u_rd;
    logic [31:0]               mag_rd;
    logic [1:0]                sk_idx;
    logic                      sk_neg;
    logic                      sk_zero;
    logic [3:0]                e_idx;
    logic [3:0]                r_idx;
    logic [3:0]                m_idx;
    logic signed [63:0]        prod64;
    logic signed [63:0]        prod_sh;
    logic [63:0]               sum_next;
    logic [63:0]               sq_trial;
    logic                      sq_ge;
    logic                      div_ge;
    logic [33:0]               div_pd;
    logic [Q_W-1:0]            div_qf;
    logic [31:0]               div_qx;
    logic [ANG_W-1:0]          mod_tp;
    logic signed [ANG_W-1:0]   fold_a0;
    logic signed [ANG_W-1:0]   fold_a1;
    logic signed [ANG_W-1:0]   fold_a2;
    logic                      fold_neg;
    logic signed [CORD_W-1:0]  cx_sh;
    logic signed [CORD_W-1:0]  cy_sh;
    logic signed [CORD_W-1:0]  cos_full;
    logic signed [63:0]        acc_next;
    logic signed [63:0]        acc_sh;
    logic signed [31:0]        acc_sat;
    logic                      last_ij;

    function automatic logic [3:0] idx3(input logic [1:0] a, input logic [1:0] b);
        return {1'b0, a, 1'b0} + {2'b00, a} + {2'b00, b};
    endfunction

    function automatic logic [31:0] absv(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    always_comb
    begin
        e_idx   = idx3(i_reg, j_reg);
        r_idx   = idx3(i_reg, k_reg);
        m_idx   = idx3(k_reg, j_reg);
        last_ij = (i_reg == 2'd2) && (j_reg == 2'd2);
        mag_rd  = mag_reg[idx_reg];

        // Cross-product matrix of the unit axis.
        unique case ({i_reg, j_reg})
            4'b0001: begin sk_idx = 2'd2; sk_neg = 1'b1; sk_zero = 1'b0; end
            4'b0010: begin sk_idx = 2'd1; sk_neg = 1'b0; sk_zero = 1'b0; end
            4'b0100: begin sk_idx = 2'd2; sk_neg = 1'b0; sk_zero = 1'b0; end
            4'b0110: begin sk_idx = 2'd0; sk_neg = 1'b1; sk_zero = 1'b0; end
            4'b1000: begin sk_idx = 2'd1; sk_neg = 1'b1; sk_zero = 1'b0; end
            4'b1001: begin sk_idx = 2'd0; sk_neg = 1'b0; sk_zero = 1'b0; end
            default: begin sk_idx = 2'd0; sk_neg = 1'b0; sk_zero = 1'b1; end
        endcase

        unique case (state_reg)
            ST_UUT:  u_rd_idx = j_reg;
            ST_SINM: u_rd_idx = sk_idx;
            default: u_rd_idx = i_reg;
        endcase
        u_rd = u_reg[u_rd_idx];

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SUMSQ:
            begin
                mul_a = $signed({1'b0, mag_rd});
                mul_b = $signed({1'b0, mag_rd});
            end
            ST_UUT:
            begin
                mul_a = MUL_W'(ua_reg);
                mul_b = MUL_W'(u_rd);
            end
            ST_COSM:
            begin
                mul_a = c_reg;
                mul_b = ((i_reg == j_reg) ? ONE33 : '0) - uut_reg;
            end
            ST_SINM:
            begin
                mul_a = s_reg;
                if (sk_zero)
                    mul_b = '0;
                else if (sk_neg)
                    mul_b = -MUL_W'(u_rd);
                else
                    mul_b = MUL_W'(u_rd);
            end
            ST_RMUL:
            begin
                mul_a = MUL_W'($signed(rot_reg[r_idx]));
                mul_b = MUL_W'(mb_reg[m_idx]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod64   = prod_reg[63:0];
        prod_sh  = prod64 >>> FRAC_BITS;
        sum_next = sum_reg + prod_reg[63:0];

        sq_trial = sq_res_reg + sq_bit_reg;
        sq_ge    = sq_op_reg >= sq_trial;

        div_ge = div_p_reg >= {2'b00, norm_reg};
        div_pd = div_ge ? (div_p_reg - {2'b00, norm_reg}) : div_p_reg;
        div_qf = {div_q_reg[Q_W-2:0], div_ge};
        div_qx = {{(32-Q_W){1'b0}}, div_qf};

        mod_tp = Q30_TWO_PI << mod_cnt_reg;

        fold_a0 = angle_reg[19] ? -$signed(amag_reg) : $signed(amag_reg);
        if (fold_a0 > Q30_PI)
            fold_a1 = fold_a0 - Q30_TWO_PI;
        else if (fold_a0 < -Q30_PI)
            fold_a1 = fold_a0 + Q30_TWO_PI;
        else
            fold_a1 = fold_a0;
        // Angles beyond a quarter turn are mirrored, which flips the sign of cosine.
        if (fold_a1 > Q30_HALF_PI)
        begin
            fold_a2  = Q30_PI - fold_a1;
            fold_neg = 1'b1;
        end
        else if (fold_a1 < -Q30_HALF_PI)
        begin
            fold_a2  = -Q30_PI - fold_a1;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_a2  = fold_a1;
            fold_neg = 1'b0;
        end

        cx_sh    = x_reg >>> cord_cnt_reg;
        cy_sh    = y_reg >>> cord_cnt_reg;
        cos_full = negcos_reg ? -x_reg : x_reg;

        acc_next = acc_reg + prod64;
        acc_sh   = acc_next >>> FRAC_BITS;
        if (acc_sh > 64'sd2147483647)
            acc_sat = 32'sh7fffffff;
        else if (acc_sh < -64'sd2147483648)
            acc_sat = 32'sh80000000;
        else
            acc_sat = acc_sh[31:0];
    end

    // Shared multiplier; its product is used in the cycle after the operands are chosen.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int n = 0; n < 9; n++)
            begin
                rot_reg[n] <= (n == 0 || n == 4 || n == 8) ? ONE32 : '0;
                mb_reg[n]  <= '0;
                nxt_reg[n] <= '0;
            end
            tr_reg       <= '0;
            for (int n = 0; n < 3; n++)
            begin
                mag_reg[n] <= '0;
                u_reg[n]   <= '0;
            end
            sign_reg     <= '0;
            angle_reg    <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            sq_op_reg    <= '0;
            sq_res_reg   <= '0;
            sq_bit_reg   <= '0;
            norm_reg     <= '0;
            div_p_reg    <= '0;
            div_q_reg    <= '0;
            div_cnt_reg  <= '0;
            amag_reg     <= '0;
            mod_cnt_reg  <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            z_reg        <= '0;
            negcos_reg   <= 1'b0;
            cord_cnt_reg <= '0;
            c_reg        <= '0;
            s_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            ua_reg       <= '0;
            uut_reg      <= '0;
            mterm_reg    <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (!req.req_type)
                        begin
                            tr_reg[0] <= req.value_x;
                            tr_reg[1] <= req.value_y;
                            tr_reg[2] <= req.value_z;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            mag_reg[0] <= absv(req.value_x);
                            mag_reg[1] <= absv(req.value_y);
                            mag_reg[2] <= absv(req.value_z);
                            sign_reg   <= {req.value_z[31], req.value_y[31],
                                           req.value_x[31]};
                            angle_reg  <= req.angle;
                            idx_reg    <= '0;
                            sum_reg    <= '0;
                            state_reg  <= ST_SUMSQ;
                        end
                    end
                end
                ST_SUMSQ:
                begin
                    state_reg <= ST_SUMACC;
                end
                ST_SUMACC:
                begin
                    sum_reg <= sum_next;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg <= '0;
                        if (sum_next == '0)
                            state_reg <= ST_OUT;
                        else
                        begin
                            sq_op_reg  <= sum_next;
                            sq_res_reg <= '0;
                            sq_bit_reg <= 64'd1 << 62;
                            state_reg  <= ST_SQRT;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_SUMSQ;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_op_reg  <= sq_op_reg - sq_trial;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_reg <= sq_res_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0])
                        state_reg <= ST_DIVI;
                end
                ST_DIVI:
                begin
                    norm_reg    <= sq_res_reg[31:0];
                    div_p_reg   <= {2'b00, mag_rd};
                    div_q_reg   <= '0;
                    div_cnt_reg <= DC_W'(FRAC_BITS);
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_p_reg   <= {div_pd[32:0], 1'b0};
                    div_q_reg   <= div_qf;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                    begin
                        u_reg[idx_reg] <= sign_reg[idx_reg] ? -$signed(div_qx)
                                                            : $signed(div_qx);
                        if (idx_reg == 2'd2)
                            state_reg <= ST_MODI;
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_DIVI;
                        end
                    end
                end
                ST_MODI:
                begin
                    amag_reg    <= ANG_W'(absv(32'(angle_reg))) << SH;
                    mod_cnt_reg <= 4'(MOD_STEPS - 1);
                    state_reg   <= ST_MOD;
                end
                ST_MOD:
                begin
                    if (amag_reg >= mod_tp)
                        amag_reg <= amag_reg - mod_tp;
                    mod_cnt_reg <= mod_cnt_reg - 4'd1;
                    if (mod_cnt_reg == '0)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    z_reg        <= fold_a2[CORD_W-1:0];
                    negcos_reg   <= fold_neg;
                    x_reg        <= Q30_CORDIC_GAIN;
                    y_reg        <= '0;
                    cord_cnt_reg <= '0;
                    state_reg    <= ST_CORDIC;
                end
                ST_CORDIC:
                begin
                    if (!z_reg[CORD_W-1])
                    begin
                        x_reg <= x_reg - cy_sh;
                        y_reg <= y_reg + cx_sh;
                        z_reg <= z_reg - atan_q30(cord_cnt_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + cy_sh;
                        y_reg <= y_reg - cx_sh;
                        z_reg <= z_reg + atan_q30(cord_cnt_reg);
                    end
                    cord_cnt_reg <= cord_cnt_reg + 5'd1;
                    if (cord_cnt_reg == 5'(STEPS - 1))
                        state_reg <= ST_CSFIN;
                end
                ST_CSFIN:
                begin
                    c_reg     <= MUL_W'(cos_full >>> SH);
                    s_reg     <= MUL_W'(y_reg >>> SH);
                    i_reg     <= '0;
                    j_reg     <= '0;
                    state_reg <= ST_UUTA;
                end
                ST_UUTA:
                begin
                    ua_reg    <= u_rd;
                    state_reg <= ST_UUT;
                end
                ST_UUT:
                begin
                    state_reg <= ST_UUTACC;
                end
                ST_UUTACC:
                begin
                    uut_reg   <= MUL_W'(prod_sh);
                    mterm_reg <= 34'(prod_sh);
                    state_reg <= ST_COSM;
                end
                ST_COSM:
                begin
                    state_reg <= ST_COSACC;
                end
                ST_COSACC:
                begin
                    mterm_reg <= mterm_reg + 34'(prod_sh);
                    state_reg <= ST_SINM;
                end
                ST_SINM:
                begin
                    state_reg <= ST_SINACC;
                end
                ST_SINACC:
                begin
                    mb_reg[e_idx] <= 32'(mterm_reg + 34'(prod_sh));
                    if (last_ij)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_RMUL;
                    end
                    else
                    begin
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + 2'd1;
                        end
                        else
                            j_reg <= j_reg + 2'd1;
                        state_reg <= ST_UUTA;
                    end
                end
                ST_RMUL:
                begin
                    state_reg <= ST_RACC;
                end
                ST_RACC:
                begin
                    if (k_reg == 2'd2)
                    begin
                        nxt_reg[e_idx] <= acc_sat;
                        acc_reg        <= '0;
                        k_reg          <= '0;
                        if (last_ij)
                            state_reg <= ST_COMMIT;
                        else
                        begin
                            if (j_reg == 2'd2)
                            begin
                                j_reg <= '0;
                                i_reg <= i_reg + 2'd1;
                            end
                            else
                                j_reg <= j_reg + 2'd1;
                            state_reg <= ST_RMUL;
                        end
                    end
                    else
                    begin
                        acc_reg   <= acc_next;
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_RMUL;
                    end
                end
                ST_COMMIT:
                begin
                    for (int n = 0; n < 9; n++)
                        rot_reg[n] <= nxt_reg[n];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (rsp.ready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_OUT);
    assign rsp.m00   = rot_reg[0];
    assign rsp.m01   = rot_reg[1];
    assign rsp.m02   = rot_reg[2];
    assign rsp.m10   = rot_reg[3];
    assign rsp.m11   = rot_reg[4];
    assign rsp.m12   = rot_reg[5];
    assign rsp.m20   = rot_reg[6];
    assign rsp.m21   = rot_reg[7];
    assign rsp.m22   = rot_reg[8];
    assign rsp.pos_x = tr_reg[0];
    assign rsp.pos_y = tr_reg[1];
    assign rsp.pos_z = tr_reg[2];

    // Only one item is in flight: no item is taken while a result is offered.
    assert property (@(posedge clk) disable iff (!rst_n) req.ready |-> !rsp.valid)
        else $error("input taken while a result is pending");

    // A set-position item is answered on the next cycle with the new position; pos_x and pos_z are checked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !req.req_type) |=>
        (rsp.valid && rsp.pos_x == $past(req.value_x) && rsp.pos_z == $past(req.value_z)))
        else $error("set-position result missing or wrong");

    // The rotation changes only when a finished product is committed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COMMIT) |=> $stable(rot_reg))
        else $error("rotation changed outside commit");

endmodule

// ===== tb/tb_axis_angle_transform_accumulator.sv =====
`default_nettype none

module tb_axis_angle_transform_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    import aata_pkg::*;

    localparam int FRAC = 16;
    localparam int STEPS = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1730;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int SETTLE_CYCLES = 400;

    typedef enum bit { SET_POSITION = 1'b0, ROTATE = 1'b1 } req_kind_t;

    typedef struct {
        req_kind_t          kind;
        logic signed [19:0] angle;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } request_t;

    // m00..m22, then pos_x, pos_y, pos_z.
    typedef logic [11:0][31:0] pose_t;

    logic clk;
    logic rst_n;

    aata_req_if req ();
    aata_rsp_if rsp ();

    axis_angle_transform_accumulator #(
        .FRAC_BITS   (FRAC),
        .CORDIC_STEPS(STEPS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    const longint atan_table[24] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    const string field_names[12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                     "m20", "m21", "m22", "pos_x", "pos_y", "pos_z"};

    request_t pending_requests[$];
    pose_t    expected_poses[$];

    logic signed [31:0] rot_matrix[9];
    logic signed [31:0] position[3];

    int  mismatches;
    int  requests_done;
    int  poses_seen;
    int  idle_cycles;
    bit  stimulus_done;
    int  burst_left;
    int  gap_left;
    int  hold_left;
    bit  hold_used;
    int  stall_mode;

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned op;
        longint unsigned res;
        longint unsigned b;
        op = n;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > op)
            b >>= 2;
        while (b != 0)
        begin
            if (op >= res + b)
            begin
                op -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void cordic_sin_cos(input longint ang, output longint s,
                                           output longint c);
        longint a;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip_cos;
        a = ang * (64'sd1 <<< (30 - FRAC));
        flip_cos = 0;
        a = a % longint'(Q30_TWO_PI);
        if (a > longint'(Q30_PI))
            a -= longint'(Q30_TWO_PI);
        if (a < -longint'(Q30_PI))
            a += longint'(Q30_TWO_PI);
        // Fold into the right half plane; cosine changes sign.
        if (a > longint'(Q30_HALF_PI))
        begin
            a = longint'(Q30_PI) - a;
            flip_cos = 1;
        end
        else if (a < -longint'(Q30_HALF_PI))
        begin
            a = -longint'(Q30_PI) - a;
            flip_cos = 1;
        end
        x = longint'(Q30_CORDIC_GAIN);
        y = 0;
        z = a;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_table[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_table[i];
            end
        end
        if (flip_cos)
            x = -x;
        c = x >>> (30 - FRAC);
        s = y >>> (30 - FRAC);
    endfunction

    function automatic void rotate_about_axis(input longint ang, input longint v[3]);
        longint unsigned mag[3];
        longint unsigned sum;
        longint unsigned norm;
        longint u[3];
        longint skew[3][3];
        longint uut;
        longint m[3][3];
        longint s;
        longint c;
        longint d;
        longint acc;
        logic signed [31:0] next[9];
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            sum += mag[i] * mag[i];
        end
        if (sum == 0)
            return;
        norm = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'((mag[i] << FRAC) / norm);
            if (v[i] < 0)
                u[i] = -u[i];
        end
        cordic_sin_cos(ang, s, c);
        skew[0][0] = 0;     skew[0][1] = -u[2]; skew[0][2] = u[1];
        skew[1][0] = u[2];  skew[1][1] = 0;     skew[1][2] = -u[0];
        skew[2][0] = -u[1]; skew[2][1] = u[0];  skew[2][2] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                d = (i == j) ? (64'sd1 <<< FRAC) : 0;
                uut = (u[i] * u[j]) >>> FRAC;
                m[i][j] = uut + ((c * (d - uut)) >>> FRAC) + ((s * skew[i][j]) >>> FRAC);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += longint'(rot_matrix[i * 3 + k]) * m[k][j];
                acc = acc >>> FRAC;
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                next[i * 3 + j] = acc[31:0];
            end
        rot_matrix = next;
    endfunction

    function automatic pose_t apply_request(request_t r);
        longint v[3];
        pose_t  p;
        v[0] = r.vx;
        v[1] = r.vy;
        v[2] = r.vz;
        if (r.kind == SET_POSITION)
        begin
            position[0] = r.vx;
            position[1] = r.vy;
            position[2] = r.vz;
        end
        else
            rotate_about_axis(longint'(r.angle), v);
        for (int i = 0; i < 9; i++)
            p[i] = rot_matrix[i];
        for (int i = 0; i < 3; i++)
            p[9 + i] = position[i];
        return p;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 4000) - 2000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0000;
            3: return $urandom_range(0, 400000) - 200000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [19:0] rand_angle();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 20'sd411775 : -20'sd411775;
        return 20'($urandom_range(0, 823550) - 411775);
    endfunction

    task automatic queue_request(req_kind_t kind, logic signed [19:0] ang,
                                 logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
        request_t r;
        r.kind = kind;
        r.angle = ang;
        r.vx = x;
        r.vy = y;
        r.vz = z;
        pending_requests.push_back(r);
    endtask

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
    end

    // Stimulus: directed extremes first, then a random mix.
    initial
    begin
        request_t r;
        int       shape;
        stimulus_done = 0;
        for (int i = 0; i < 9; i++)
            rot_matrix[i] = (i % 4 == 0) ? 32'sd65536 : 32'sd0;
        for (int i = 0; i < 3; i++)
            position[i] = 0;

        queue_request(SET_POSITION, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        queue_request(SET_POSITION, -20'sd411775, -1, 1, 32'sh0001_0000);
        queue_request(ROTATE, 20'sd102944, 0, 0, 0);
        queue_request(ROTATE, 0, 0, 0, 32'sh0001_0000);
        queue_request(ROTATE, 20'sd102944, 0, 0, 32'sh0001_0000);
        queue_request(ROTATE, 20'sd411775, 32'sh7fff_ffff, 0, 0);
        queue_request(ROTATE, -20'sd411775, 0, 32'sh8000_0000, 0);
        queue_request(ROTATE, 20'sd205887, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        queue_request(ROTATE, -20'sd205887, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        queue_request(ROTATE, 20'sd154416, 1, 0, 0);
        queue_request(ROTATE, -20'sd154416, 0, -1, 0);
        queue_request(ROTATE, 20'sd300000, 1, 2, 3);
        queue_request(ROTATE, -20'sd300000, -5, 7, -11);
        queue_request(ROTATE, 20'sd524287, 0, 0, -32'sd65536);
        queue_request(ROTATE, 20'sh80000, 32'sd65536, 0, 0);
        queue_request(SET_POSITION, 20'sd1, 0, 0, 0);
        queue_request(ROTATE, 20'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        queue_request(ROTATE, -20'sd1, 3, 4, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            shape = $urandom_range(0, 9);
            r.kind = (shape < 3) ? SET_POSITION : ROTATE;
            r.angle = rand_angle();
            r.vx = rand_word();
            r.vy = rand_word();
            r.vz = rand_word();
            if (shape == 9)
            begin
                r.vx = 0;
                r.vy = 0;
                r.vz = 0;
            end
            pending_requests.push_back(r);
        end
        stimulus_done = 1;
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            req.valid <= 0;
            req.req_type <= 0;
            req.angle <= 0;
            req.value_x <= 0;
            req.value_y <= 0;
            req.value_z <= 0;
            burst_left <= 0;
            gap_left <= 0;
            requests_done <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                r.kind = req_kind_t'(req.req_type);
                r.angle = req.angle;
                r.vx = req.value_x;
                r.vy = req.value_y;
                r.vz = req.value_z;
                expected_poses.push_back(apply_request(r));
                requests_done <= requests_done + 1;
            end
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    req.valid <= 0;
                end
                else if (pending_requests.size() > 0)
                begin
                    r = pending_requests.pop_front();
                    req.valid <= 1;
                    req.req_type <= r.kind;
                    req.angle <= r.angle;
                    req.value_x <= r.vx;
                    req.value_y <= r.vy;
                    req.value_z <= r.vz;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req.valid <= 0;
            end
        end
    end

    // Result checker with its own stall pattern and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        pose_t got;
        pose_t want;
        bit    bad;
        if (!rst_n)
        begin
            rsp.ready <= 0;
            mismatches <= 0;
            poses_seen <= 0;
            idle_cycles <= 0;
            hold_left <= 0;
            hold_used <= 0;
            stall_mode <= 0;
        end
        else
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("axis_angle_transform_accumulator verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;

            if (rsp.valid && rsp.ready)
            begin
                poses_seen <= poses_seen + 1;
                got = {rsp.pos_z, rsp.pos_y, rsp.pos_x, rsp.m22, rsp.m21, rsp.m20,
                       rsp.m12, rsp.m11, rsp.m10, rsp.m02, rsp.m01, rsp.m00};
                if (expected_poses.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result item at %0t", $realtime);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_poses.pop_front();
                    bad = 0;
                    for (int i = 0; i < 12; i++)
                        if (got[i] !== want[i])
                        begin
                            bad = 1;
                            if (mismatches < 10)
                                $display("item %0d %s: expected %0d, got %0d", poses_seen,
                                         field_names[i], $signed(want[i]), $signed(got[i]));
                        end
                    if (bad)
                        mismatches <= mismatches + 1;
                end
            end

            // The long hold-off keeps a result pending while requests keep coming and stay untaken.
            if (!hold_used && poses_seen == 300)
            begin
                hold_used <= 1;
                hold_left <= HOLD_OFF_CYCLES;
                rsp.ready <= 0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    stall_mode <= $urandom_range(0, 3);
                case (stall_mode)
                    0: rsp.ready <= 1;
                    1: rsp.ready <= $urandom_range(0, 1);
                    2: rsp.ready <= ($urandom_range(0, 7) == 0);
                    default: rsp.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (stimulus_done && pending_requests.size() == 0);
        @(posedge clk);
        while (req.valid || expected_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_poses.size() == 0)
            $display("axis_angle_transform_accumulator verification clean");
        else
            $display("axis_angle_transform_accumulator verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/aata_pkg.sv
hdl/aata_req_if.sv
hdl/aata_rsp_if.sv
hdl/axis_angle_transform_accumulator.sv
tb/tb_axis_angle_transform_accumulator.sv
